@@ sv/lqsu_pkg.sv @@
// Shared types and constants for the linear queue with search and update.
package lqsu_pkg;

    localparam int WORD_W = 32;
    localparam int IDX_W  = 7;
    localparam int CAP_W  = 8;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_ENQ    = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ    = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd3;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    typedef struct packed {
        logic capture;
        logic set_ovf;
        logic set_empty;
        logic set_notfound;
        logic enq_write;
        logic rd_head;
        logic deq_take;
        logic scan_start;
        logic scan_step;
        logic found;
        logic load_out;
    } lqsu_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            match;
        logic            scan_done;
    } lqsu_sts_t;

endpackage

@@ sv/lqsu_ctrl.sv @@
// Sequencer for the queue: one item at a time, output register release.
module lqsu_ctrl
    import lqsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  lqsu_sts_t sts,
    output lqsu_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DEQ  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_HEAD = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.op)
                    OP_ENQ:
                    begin
                        if (sts.full)
                            cmd.set_ovf = 1'b1;
                        else
                            cmd.enq_write = 1'b1;
                        state_next = S_HEAD;
                    end
                    OP_DEQ:
                    begin
                        if (sts.empty)
                        begin
                            cmd.set_empty = 1'b1;
                            state_next    = S_HEAD;
                        end
                        else
                        begin
                            cmd.rd_head = 1'b1;
                            state_next  = S_DEQ;
                        end
                    end
                    default:
                    begin
                        if (sts.empty)
                        begin
                            cmd.set_empty = 1'b1;
                            state_next    = S_HEAD;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                endcase
            end
            S_DEQ:
            begin
                cmd.deq_take = 1'b1;
                state_next   = S_HEAD;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.match)
                begin
                    cmd.found  = 1'b1;
                    state_next = S_HEAD;
                end
                else if (sts.scan_done)
                begin
                    cmd.set_notfound = 1'b1;
                    state_next       = S_HEAD;
                end
            end
            S_HEAD:
            begin
                // head word read; data lands in the read register next cycle
                cmd.rd_head = 1'b1;
                state_next  = S_RES;
            end
            S_RES:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out | (out_valid_reg & out_stall);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // never overwrite a result that is still waiting for its transfer
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && out_stall))
        else $error("result register overwritten while stalled");

    a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_EXEC))
        else $error("accepted item not executed");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("result dropped while stalled");

endmodule

@@ sv/lqsu_dp.sv @@
// Queue datapath: slot memory, pointers, scan counters and result registers.
module lqsu_dp
    import lqsu_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lqsu_cmd_t                cmd,
    output lqsu_sts_t                sts,
    input  logic                     cfg_wr_en,
    input  logic        [CAP_W-1:0]  cfg_wr_data,
    input  logic        [OP_W-1:0]   operation,
    input  logic signed [WORD_W-1:0] value,
    input  logic signed [WORD_W-1:0] new_value,
    output logic        [ST_W-1:0]   status,
    output logic        [IDX_W-1:0]  index,
    output logic signed [WORD_W-1:0] data,
    output logic signed [WORD_W-1:0] head_value,
    output logic                     empty_res
);

    localparam int AW   = $clog2(DEPTH);
    localparam int PW   = $clog2(DEPTH + 1);
    localparam int CMPW = (PW > CAP_W) ? PW : CAP_W;

    logic [WORD_W-1:0] slots_mem [DEPTH];

    // control state
    logic [CAP_W-1:0] cap_reg,       cap_next;
    logic [PW-1:0]    head_reg,      head_next;
    logic [PW-1:0]    tail_reg,      tail_next;
    logic [PW-1:0]    issue_reg,     issue_next;
    logic             cmp_valid_reg, cmp_valid_next;

    // payload
    logic [OP_W-1:0]   op_reg,       op_next;
    logic [WORD_W-1:0] key_reg,      key_next;
    logic [WORD_W-1:0] nval_reg,     nval_next;
    logic [PW-1:0]     cmp_ptr_reg,  cmp_ptr_next;
    logic [ST_W-1:0]   st_reg,       st_next;
    logic [IDX_W-1:0]  idx_reg,      idx_next;
    logic [WORD_W-1:0] deq_reg,      deq_next;
    logic [WORD_W-1:0] rd_data_reg;
    logic [ST_W-1:0]   status_reg,   status_next;
    logic [IDX_W-1:0]  index_reg,    index_next;
    logic [WORD_W-1:0] data_reg,     data_next;
    logic [WORD_W-1:0] headv_reg,    headv_next;
    logic              empty_reg,    empty_next;

    logic              q_empty;
    logic              q_full;
    logic              issue_more;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [WORD_W-1:0] mem_wd;
    logic              mem_re;
    logic [AW-1:0]     mem_ra;

    assign q_empty    = (head_reg >= tail_reg);
    assign q_full     = (CMPW'(tail_reg) >= CMPW'(cap_reg)) || (tail_reg >= PW'(DEPTH));
    assign issue_more = (issue_reg < tail_reg);

    assign sts.op        = op_reg;
    assign sts.empty     = q_empty;
    assign sts.full      = q_full;
    assign sts.match     = cmp_valid_reg && (rd_data_reg == key_reg);
    assign sts.scan_done = !issue_more && !cmp_valid_reg;

    assign mem_we = cmd.enq_write | (cmd.found & (op_reg == OP_UPDATE));
    assign mem_wa = cmd.enq_write ? tail_reg[AW-1:0] : cmp_ptr_reg[AW-1:0];
    assign mem_wd = cmd.enq_write ? key_reg : nval_reg;
    assign mem_re = cmd.rd_head | (cmd.scan_step & issue_more);
    assign mem_ra = cmd.scan_step ? issue_reg[AW-1:0] : head_reg[AW-1:0];

    always_comb
    begin
        cap_next       = cap_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        issue_next     = issue_reg;
        cmp_valid_next = cmp_valid_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        nval_next      = nval_reg;
        cmp_ptr_next   = cmp_ptr_reg;
        st_next        = st_reg;
        idx_next       = idx_reg;
        deq_next       = deq_reg;
        status_next    = status_reg;
        index_next     = index_reg;
        data_next      = data_reg;
        headv_next     = headv_reg;
        empty_next     = empty_reg;

        if (cfg_wr_en)
            cap_next = cfg_wr_data;

        if (cmd.capture)
        begin
            op_next   = operation;
            key_next  = value;
            nval_next = new_value;
            st_next   = ST_OK;
            idx_next  = '0;
            deq_next  = '0;
        end
        if (cmd.set_ovf)
            st_next = ST_OVERFLOW;
        if (cmd.set_empty)
            st_next = ST_EMPTY;
        if (cmd.set_notfound)
            st_next = ST_NOT_FOUND;
        if (cmd.enq_write)
        begin
            idx_next  = IDX_W'(tail_reg);
            tail_next = tail_reg + PW'(1);
        end
        if (cmd.deq_take)
        begin
            deq_next  = rd_data_reg;
            head_next = head_reg + PW'(1);
        end
        if (cmd.scan_start)
        begin
            issue_next     = head_reg;
            cmp_valid_next = 1'b0;
        end
        if (cmd.scan_step)
        begin
            // read one slot per cycle, compare it the cycle after
            if (issue_more)
            begin
                issue_next     = issue_reg + PW'(1);
                cmp_ptr_next   = issue_reg;
                cmp_valid_next = 1'b1;
            end
            else
                cmp_valid_next = 1'b0;
        end
        if (cmd.found)
            idx_next = IDX_W'(cmp_ptr_reg);
        if (cmd.load_out)
        begin
            status_next = st_reg;
            index_next  = idx_reg;
            data_next   = deq_reg;
            headv_next  = q_empty ? '0 : rd_data_reg;
            empty_next  = q_empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        nval_reg    <= nval_next;
        cmp_ptr_reg <= cmp_ptr_next;
        st_reg      <= st_next;
        idx_reg     <= idx_next;
        deq_reg     <= deq_next;
        status_reg  <= status_next;
        index_reg   <= index_next;
        data_reg    <= data_next;
        headv_reg   <= headv_next;
        empty_reg   <= empty_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            slots_mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= slots_mem[mem_ra];
    end

    assign status     = status_reg;
    assign index      = index_reg;
    assign data       = data_reg;
    assign head_value = headv_reg;
    assign empty_res  = empty_reg;

    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("head passed tail");

    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= PW'(DEPTH))
        else $error("tail beyond depth");

    a_tail_step: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg != $past(tail_reg)) |-> (tail_reg == $past(tail_reg) + PW'(1)))
        else $error("tail moved by more than one slot");

endmodule

@@ sv/linear_queue_with_search_update_top.sv @@
// Enqueue/overflow/empty cases: execute, head-read and result states in turn, then the
// result is valid. Dequeue adds a take state after execute. Search/update: one slot read
// per cycle from the head, stopping at the first hit or after the last live entry.
// One item in flight; next input transfer the cycle after the result is registered.
// Async active-low reset empties the queue and sets capacity to 128; slot contents
// are not cleared, and no clearing pass is needed.
module linear_queue_with_search_update_top
    import lqsu_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic        [CAP_W-1:0]  cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic        [OP_W-1:0]   operation,
    input  logic signed [WORD_W-1:0] value,
    input  logic signed [WORD_W-1:0] new_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic        [ST_W-1:0]   status,
    output logic        [IDX_W-1:0]  index,
    output logic signed [WORD_W-1:0] data,
    output logic signed [WORD_W-1:0] head_value,
    output logic                     empty_res
);

    lqsu_cmd_t cmd;
    lqsu_sts_t sts;

    lqsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    lqsu_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .operation   (operation),
        .value       (value),
        .new_value   (new_value),
        .status      (status),
        .index       (index),
        .data        (data),
        .head_value  (head_value),
        .empty_res   (empty_res)
    );

endmodule
